// ----- rtl/core/iwl_pkg.sv -----
// ----------------------------------------------------------------------------
// iwl_pkg
// Shared types and constants for the indexed word list.
// ----------------------------------------------------------------------------
package iwl_pkg;

   localparam int WORD_W = 64;
   localparam int FUNC_W = 3;
   localparam int POS_W  = 8;
   localparam int LEN_W  = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH   = 3'd0,
      FUNC_POP    = 3'd1,
      FUNC_READ   = 3'd2,
      FUNC_INSERT = 3'd3,
      FUNC_REMOVE = 3'd4
   } func_type;

   // per-cycle shift command broadcast along the cell row
   typedef struct packed {
      logic ins;   // open a slot at k, tail moves back one place
      logic rem;   // close the slot at k, tail moves forward one place
   } shift_ctl_type;

endpackage

// ----- rtl/core/iwl_cell.sv -----
// ----------------------------------------------------------------------------
// iwl_cell
// One list slot: holds a word and loads from its neighbor or the bus on shift.
// ----------------------------------------------------------------------------
module iwl_cell #(
   parameter int IDX  = 0,
   parameter int KW   = 8
) (
   input  logic                    clock,
   input  iwl_pkg::shift_ctl_type  ctl,
   input  logic [KW-1:0]           k,
   input  logic [iwl_pkg::WORD_W-1:0] bus_word,
   input  logic [iwl_pkg::WORD_W-1:0] left_word,
   input  logic [iwl_pkg::WORD_W-1:0] right_word,
   output logic [iwl_pkg::WORD_W-1:0] word,
   output logic                    hit
);

   logic [iwl_pkg::WORD_W-1:0] word_ff;
   logic [iwl_pkg::WORD_W-1:0] word_in;
   logic                       at_k;
   logic                       past_k;

   assign at_k   = (k == KW'(IDX));
   assign past_k = (KW'(IDX) > k);

   always_comb begin
      word_in = word_ff;
      if (ctl.ins) begin
         if (at_k) begin
            word_in = bus_word;
         end else if (past_k) begin
            word_in = left_word;
         end
      end else if (ctl.rem) begin
         if (at_k || past_k) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   assign hit  = at_k;

endmodule

// ----- rtl/core/indexed_word_list.sv -----
// ----------------------------------------------------------------------------
// indexed_word_list
// Ordered list of 64-bit words held in a row of shift cells, with push/pop at
// the front and read/insert/remove at an index.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | func, position, word_in
//   rsp     | out       | rsp_valid/rsp_stall | word_out, found, dropped, length
//
// One item per cycle when not stalled: every cell shifts or holds in parallel
// in the accept cycle and the registered result shows in the cycle after.
// The output register is the only buffer; req_stall is high while a result
// waits under rsp_stall and while reset is high. Synchronous reset empties
// the list; cell contents are not cleared and are never read past the count.
// ----------------------------------------------------------------------------
module indexed_word_list #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [iwl_pkg::FUNC_W-1:0]    req_func,
   input  logic [iwl_pkg::POS_W-1:0]     req_position,
   input  logic [iwl_pkg::WORD_W-1:0]    req_word_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [iwl_pkg::WORD_W-1:0]    rsp_word_out,
   output logic                          rsp_found,
   output logic                          rsp_dropped,
   output logic [iwl_pkg::LEN_W-1:0]     rsp_length
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > iwl_pkg::POS_W) ? CW : iwl_pkg::POS_W;

   logic [CW-1:0]               count_ff, count_in;
   logic                        rsp_valid_ff;
   logic [iwl_pkg::WORD_W-1:0]  word_out_ff, word_out_in;
   logic                        found_ff, found_in;
   logic                        dropped_ff, dropped_in;
   logic [iwl_pkg::LEN_W-1:0]   length_ff;

   logic                        accept;
   logic                        full;
   logic [XW-1:0]               pos_x, cnt_x, k;
   iwl_pkg::shift_ctl_type      ctl;
   logic                        want_ins, want_rem, is_take;
   logic [iwl_pkg::WORD_W-1:0]  cell_word [CAPACITY];
   logic [CAPACITY-1:0]         cell_hit;
   logic [iwl_pkg::WORD_W-1:0]  rd_word;

   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(CAPACITY));
   assign pos_x     = XW'(req_position);
   assign cnt_x     = XW'(count_ff);

   always_comb begin
      k        = '0;
      want_ins = 1'b0;
      want_rem = 1'b0;
      is_take  = 1'b0;
      case (req_func)
         iwl_pkg::FUNC_PUSH: begin
            want_ins = !full;
         end
         iwl_pkg::FUNC_POP: begin
            want_rem = (count_ff != '0);
            is_take  = 1'b1;
         end
         iwl_pkg::FUNC_READ: begin
            k       = pos_x;
            is_take = 1'b1;
         end
         iwl_pkg::FUNC_INSERT: begin
            k        = (pos_x >= cnt_x) ? cnt_x : pos_x;
            want_ins = !full;
         end
         iwl_pkg::FUNC_REMOVE: begin
            k        = pos_x;
            want_rem = (pos_x < cnt_x);
            is_take  = 1'b1;
         end
         default: begin
         end
      endcase
      ctl.ins = accept && want_ins;
      ctl.rem = accept && want_rem;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [iwl_pkg::WORD_W-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = cell_word[i];
      end else begin : g_mid_l
         assign left_w = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = cell_word[i];
      end else begin : g_mid_r
         assign right_w = cell_word[i+1];
      end
      iwl_cell #(
         .IDX (i),
         .KW  (XW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .k          (k),
         .bus_word   (req_word_in),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (cell_word[i]),
         .hit        (cell_hit[i])
      );
   end

   // one-hot select of the addressed cell
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_word = rd_word | (cell_hit[i] ? cell_word[i] : '0);
      end
   end

   always_comb begin
      found_in    = is_take && (k < cnt_x);
      word_out_in = found_in ? rd_word : '0;
      dropped_in  = ((req_func == iwl_pkg::FUNC_PUSH) ||
                     (req_func == iwl_pkg::FUNC_INSERT)) && full;
      count_in    = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.rem) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_out_ff <= word_out_in;
         found_ff    <= found_in;
         dropped_ff  <= dropped_in;
         length_ff   <= iwl_pkg::LEN_W'(count_in);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word_out = word_out_ff;
   assign rsp_found    = found_ff;
   assign rsp_dropped  = dropped_ff;
   assign rsp_length   = length_ff;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for indexed_word_list. A scoreboard class keeps its own
// copy of the list, predicts one result per accepted item and compares every
// accepted result field by field. Stimulus is a short directed run followed
// by random grow/shrink/mixed episodes, with bursty requests and a
// randomly driven response stall.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_CAP    = 16;
   localparam int RANDOM_OPS  = 2000;
   localparam int IDLE_LIMIT  = 5000;

   typedef struct {
      logic [iwl_pkg::WORD_W-1:0] word;
      logic                       found;
      logic                       dropped;
      logic [iwl_pkg::LEN_W-1:0]  length;
   } list_result_type;

   typedef enum {TRAFFIC_GROW, TRAFFIC_SHRINK, TRAFFIC_EVEN} traffic_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_type;

   class word_list_board_type;
      logic [iwl_pkg::WORD_W-1:0] cells [LIST_CAP];
      int unsigned                held;
      list_result_type            expected_results [$];
      int unsigned                mismatches;

      function new();
         held       = 0;
         mismatches = 0;
      endfunction

      // returns 1 when the list is full and the word is refused
      function logic put_word(int unsigned k, logic [iwl_pkg::WORD_W-1:0] w);
         if (held >= LIST_CAP) return 1'b1;
         if (k > held) k = held;
         for (int unsigned j = held; j > k; j--) cells[j] = cells[j-1];
         cells[k] = w;
         held++;
         return 1'b0;
      endfunction

      function logic take_word(int unsigned k, output logic [iwl_pkg::WORD_W-1:0] w);
         w = '0;
         if (k >= held) return 1'b0;
         w = cells[k];
         for (int unsigned j = k; j + 1 < held; j++) cells[j] = cells[j+1];
         held--;
         return 1'b1;
      endfunction

      function void note_request(logic [iwl_pkg::FUNC_W-1:0] func,
                                 logic [iwl_pkg::POS_W-1:0] pos,
                                 logic [iwl_pkg::WORD_W-1:0] w);
         list_result_type r;
         r.word    = '0;
         r.found   = 1'b0;
         r.dropped = 1'b0;
         case (func)
            iwl_pkg::FUNC_PUSH:   r.dropped = put_word(0, w);
            iwl_pkg::FUNC_POP:    r.found = take_word(0, r.word);
            iwl_pkg::FUNC_READ: begin
               if (pos < held) begin
                  r.word  = cells[pos];
                  r.found = 1'b1;
               end
            end
            iwl_pkg::FUNC_INSERT: r.dropped = put_word(pos, w);
            iwl_pkg::FUNC_REMOVE: r.found = take_word(pos, r.word);
            default: ;
         endcase
         r.length = iwl_pkg::LEN_W'(held);
         expected_results.push_back(r);
      endfunction

      function void report(string field, logic [iwl_pkg::WORD_W-1:0] want,
                           logic [iwl_pkg::WORD_W-1:0] got);
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
      endfunction

      function void compare(string field, logic [iwl_pkg::WORD_W-1:0] want,
                            logic [iwl_pkg::WORD_W-1:0] got);
         if (got !== want) report(field, want, got);
      endfunction

      function void check_response(logic [iwl_pkg::WORD_W-1:0] word, logic found,
                                   logic dropped, logic [iwl_pkg::LEN_W-1:0] length);
         list_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual word %h length %0d",
                     $realtime, word, length);
            return;
         end
         want = expected_results.pop_front();
         compare("word_out", want.word, word);
         compare("found", iwl_pkg::WORD_W'(want.found), iwl_pkg::WORD_W'(found));
         compare("dropped", iwl_pkg::WORD_W'(want.dropped), iwl_pkg::WORD_W'(dropped));
         compare("length", iwl_pkg::WORD_W'(want.length), iwl_pkg::WORD_W'(length));
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [iwl_pkg::FUNC_W-1:0]   req_func;
   logic [iwl_pkg::POS_W-1:0]    req_position;
   logic [iwl_pkg::WORD_W-1:0]   req_word_in;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [iwl_pkg::WORD_W-1:0]   rsp_word_out;
   logic                         rsp_found;
   logic                         rsp_dropped;
   logic [iwl_pkg::LEN_W-1:0]    rsp_length;

   word_list_board_type board = new();
   int unsigned         burst_left = 0;
   int unsigned         idle_cycles = 0;
   stall_type           stall_mode = STALL_NONE;
   int unsigned         stall_span = 0;

   indexed_word_list #(.CAPACITY(LIST_CAP)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_position (req_position),
      .req_word_in  (req_word_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word_out (rsp_word_out),
      .rsp_found    (rsp_found),
      .rsp_dropped  (rsp_dropped),
      .rsp_length   (rsp_length)
   );

   always #5 clock = ~clock;

   // response stall: stretches of none, light or heavy back-pressure
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= stall_type'($urandom_range(0, 2));
         stall_span <= $urandom_range(20, 200);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         default:     rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_word_out, rsp_found, rsp_dropped, rsp_length);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("[indexed_word_list] ERROR");
      $finish;
   end

   function automatic logic [iwl_pkg::WORD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [iwl_pkg::FUNC_W-1:0] unused_func();
      return iwl_pkg::FUNC_W'($urandom_range(int'(iwl_pkg::FUNC_REMOVE) + 1,
                                             (1 << iwl_pkg::FUNC_W) - 1));
   endfunction

   function automatic logic [iwl_pkg::FUNC_W-1:0] pick_func(traffic_type mode);
      int unsigned r;
      r = $urandom_range(0, 99);
      case (mode)
         TRAFFIC_GROW: begin
            if (r < 45) return iwl_pkg::FUNC_PUSH;
            if (r < 80) return iwl_pkg::FUNC_INSERT;
            if (r < 90) return iwl_pkg::FUNC_READ;
            if (r < 95) return iwl_pkg::FUNC_POP;
            if (r < 99) return iwl_pkg::FUNC_REMOVE;
         end
         TRAFFIC_SHRINK: begin
            if (r < 40) return iwl_pkg::FUNC_POP;
            if (r < 75) return iwl_pkg::FUNC_REMOVE;
            if (r < 88) return iwl_pkg::FUNC_READ;
            if (r < 93) return iwl_pkg::FUNC_PUSH;
            if (r < 98) return iwl_pkg::FUNC_INSERT;
         end
         default: begin
            if (r < 95)
               return iwl_pkg::FUNC_W'($urandom_range(0, int'(iwl_pkg::FUNC_REMOVE)));
         end
      endcase
      return unused_func();
   endfunction

   // mostly around the live range, count and count+1 included
   function automatic logic [iwl_pkg::POS_W-1:0] pick_position();
      if ($urandom_range(0, 4) == 0) return iwl_pkg::POS_W'($urandom_range(0, 255));
      return iwl_pkg::POS_W'($urandom_range(0, board.held + 1));
   endfunction

   task automatic send_item(input logic [iwl_pkg::FUNC_W-1:0] f,
                            input logic [iwl_pkg::POS_W-1:0] p,
                            input logic [iwl_pkg::WORD_W-1:0] w);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_func     <= f;
      req_position <= p;
      req_word_in  <= w;
      do @(posedge clock); while (req_stall);
      board.note_request(f, p, w);
   endtask

   initial begin
      traffic_type mode;
      int unsigned ops_left;
      int unsigned span;

      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = iwl_pkg::FUNC_PUSH;
      req_position = '0;
      req_word_in  = '0;
      rsp_stall    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-list corners, append, shifts, bounds, unused codes
      send_item(iwl_pkg::FUNC_POP,    8'd0,   '0);
      send_item(iwl_pkg::FUNC_READ,   8'd0,   '0);
      send_item(iwl_pkg::FUNC_REMOVE, 8'd255, '0);
      send_item(iwl_pkg::FUNC_INSERT, 8'd255, '1);
      send_item(iwl_pkg::FUNC_PUSH,   8'd0,   '0);
      send_item(iwl_pkg::FUNC_INSERT, 8'd1,   64'h5555_5555_5555_5555);
      send_item(iwl_pkg::FUNC_READ,   8'd0,   '1);
      send_item(iwl_pkg::FUNC_READ,   8'd2,   '0);
      send_item(iwl_pkg::FUNC_READ,   8'd3,   '0);
      send_item(iwl_pkg::FUNC_READ,   8'd255, '0);
      send_item(iwl_pkg::FUNC_REMOVE, 8'd1,   '0);
      for (int c = int'(iwl_pkg::FUNC_REMOVE) + 1; c < (1 << iwl_pkg::FUNC_W); c++)
         send_item(iwl_pkg::FUNC_W'(c), 8'd0, '1);
      send_item(iwl_pkg::FUNC_POP,    8'd128, '0);
      send_item(iwl_pkg::FUNC_REMOVE, 8'd0,   '0);
      send_item(iwl_pkg::FUNC_INSERT, 8'd0,   64'hAAAA_AAAA_AAAA_AAAA);
      send_item(iwl_pkg::FUNC_REMOVE, 8'd1,   '0);
      send_item(iwl_pkg::FUNC_POP,    8'd0,   '0);

      // random episodes; start by growing so the full list is reached early
      mode = TRAFFIC_GROW;
      ops_left = RANDOM_OPS;
      while (ops_left > 0) begin
         span = $urandom_range(10, 60);
         if (span > ops_left) span = ops_left;
         repeat (span) send_item(pick_func(mode), pick_position(), random_word());
         ops_left -= span;
         mode = traffic_type'($urandom_range(0, 2));
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (board.mismatches == 0)
         $display("[indexed_word_list] OK");
      else
         $display("[indexed_word_list] ERROR");
      $finish;
   end

endmodule
